// ----- hdl/ocbb_pkg.sv -----
// Shared constants, types and helpers of the cylinder bounding box block.
`timescale 1ns / 1ps
package ocbb_pkg;
	localparam int AXIS_W  = 14;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 31;
	localparam int IDX_W   = 2;
	localparam int HALF_W  = 34;
	localparam int SQ_W    = 27;
	localparam int SQO_W   = 28;
	localparam int WABS_W  = 26;
	localparam int D_W     = 55;
	localparam int ROOT_W  = 28;
	localparam int NUM_W   = 57;
	localparam int HT_W    = 33;
	localparam int Q_W     = 31;
	// Stage map: 0..3 front math, 4..31 root bits, 32..62 quotient bits,
	// 63 half extent sum, 64 box bounds (output register).
	localparam int SQRT_FIRST = 4;
	localparam int DIV_FIRST  = SQRT_FIRST + ROOT_W;
	localparam int HALF_STG   = DIV_FIRST + Q_W;
	localparam int NSTG       = HALF_STG + 2;

	localparam logic [IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [IDX_W-1:0] CFG_HALF_H = 2'd1;
	localparam logic [IDX_W-1:0] CFG_MARGIN = 2'd2;

	typedef logic [NSTG-1:0] stage_en_t;

	function automatic logic [POS_W-1:0] sat32(input logic signed [HALF_W:0] v);
		logic [POS_W-1:0] r;
		r = v[POS_W-1:0];
		if (v > $signed({{(HALF_W-POS_W+2){1'b0}}, {(POS_W-1){1'b1}}}))
			r = {1'b0, {(POS_W-1){1'b1}}};
		else if (v < $signed({{(HALF_W-POS_W+2){1'b1}}, {(POS_W-1){1'b0}}}))
			r = {1'b1, {(POS_W-1){1'b0}}};
		return r;
	endfunction
endpackage

// ----- hdl/ocbb_lane.sv -----
// One axis lane: squares, radicand, bit-serial root and quotient stages.
`timescale 1ns / 1ps
module ocbb_lane (
	input  logic                             clk,
	input  ocbb_pkg::stage_en_t              en,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] a_own,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] a_o1,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] a_o2,
	input  logic [ocbb_pkg::CFG_W-1:0]       radius,
	input  logic [ocbb_pkg::CFG_W-1:0]       half_height,
	input  logic [ocbb_pkg::CFG_W-1:0]       margin,
	output logic [ocbb_pkg::HALF_W-1:0]      half
);
	import ocbb_pkg::*;
	localparam int SW = D_W + 3;
	localparam int DW = NUM_W + 2;

	logic [AXIS_W-1:0] mag_s1, mag_s2;
	logic [SQ_W-1:0]   sqa_s1, sqa_s2;
	logic [SQO_W-1:0]  sqo_s1, sqo_s2;
	logic [WABS_W-1:0] wabs_s2;
	logic [2*WABS_W-1:0] wsq_s3;
	logic [D_W-1:0]    cross_s3;
	logic [NUM_W-1:0]  num_s3;
	logic [HT_W-1:0]   ht_s3;

	logic signed [2*AXIS_W-1:0] pa, p1, p2;
	logic signed [SQO_W:0] w;
	logic [AXIS_W+CFG_W-1:0] htp;

	logic [D_W-1:0]    srem_s [ROOT_W+1];
	logic [ROOT_W-1:0] sres_s [ROOT_W+1];
	logic [NUM_W-1:0]  snum_s [ROOT_W+1];
	logic [HT_W-1:0]   sht_s  [ROOT_W+1];

	logic [NUM_W-1:0]  drem_s  [Q_W+1];
	logic [Q_W-1:0]    dq_s    [Q_W+1];
	logic [ROOT_W-1:0] droot_s [Q_W+1];
	logic [HT_W-1:0]   dht_s   [Q_W+1];

	logic [HALF_W-1:0] half_s;

	assign pa = a_own * a_own;
	assign p1 = a_o1 * a_o1;
	assign p2 = a_o2 * a_o2;
	assign w  = (SQO_W+1)'(1 << 24) - $signed({2'b0, sqa_s1});
	assign htp = mag_s2 * half_height;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1 <= a_own[AXIS_W-1] ? AXIS_W'(-a_own) : a_own;
			sqa_s1 <= pa[SQ_W-1:0];
			sqo_s1 <= SQO_W'(p1[SQ_W-1:0]) + SQO_W'(p2[SQ_W-1:0]);
		end
		if (en[1]) begin
			mag_s2  <= mag_s1;
			sqa_s2  <= sqa_s1;
			sqo_s2  <= sqo_s1;
			wabs_s2 <= w[SQO_W] ? WABS_W'(-w) : WABS_W'(w);
		end
		if (en[2]) begin
			wsq_s3   <= wabs_s2 * wabs_s2;
			cross_s3 <= sqa_s2 * sqo_s2;
			num_s3   <= wabs_s2 * radius;
			ht_s3    <= htp[AXIS_W+CFG_W-1:12];
		end
		if (en[3]) begin
			srem_s[0] <= D_W'(wsq_s3) + cross_s3;
			sres_s[0] <= '0;
			snum_s[0] <= num_s3;
			sht_s[0]  <= ht_s3;
		end
	end

	// Square root: one result bit per stage, most significant first.
	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int K = ROOT_W - 1 - j;
		logic [SW-1:0] t;
		assign t = (SW'(sres_s[j]) << (K + 1)) | (SW'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en[SQRT_FIRST+j]) begin
				snum_s[j+1] <= snum_s[j];
				sht_s[j+1]  <= sht_s[j];
				if (SW'(srem_s[j]) >= t) begin
					srem_s[j+1] <= D_W'(SW'(srem_s[j]) - t);
					sres_s[j+1] <= sres_s[j] | (ROOT_W'(1) << K);
				end else begin
					srem_s[j+1] <= srem_s[j];
					sres_s[j+1] <= sres_s[j];
				end
			end
		end
	end

	assign drem_s[0]  = snum_s[ROOT_W];
	assign dq_s[0]    = '0;
	assign droot_s[0] = sres_s[ROOT_W];
	assign dht_s[0]   = sht_s[ROOT_W];

	// Restoring divide: one quotient bit per stage; quotient stays below 2^31.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int B = Q_W - 1 - j;
		logic [DW-1:0] trial;
		assign trial = DW'(droot_s[j]) << B;
		always_ff @(posedge clk) begin
			if (en[DIV_FIRST+j]) begin
				droot_s[j+1] <= droot_s[j];
				dht_s[j+1]   <= dht_s[j];
				if (DW'(drem_s[j]) >= trial) begin
					drem_s[j+1] <= NUM_W'(DW'(drem_s[j]) - trial);
					dq_s[j+1]   <= dq_s[j] | (Q_W'(1) << B);
				end else begin
					drem_s[j+1] <= drem_s[j];
					dq_s[j+1]   <= dq_s[j];
				end
			end
		end
	end

	// Drop the disc term when the root is zero.
	always_ff @(posedge clk) begin
		if (en[HALF_STG])
			half_s <= HALF_W'(dht_s[Q_W]) + HALF_W'(margin)
				+ ((droot_s[Q_W] != '0) ? HALF_W'(dq_s[Q_W]) : '0);
	end

	assign half = half_s;
endmodule

// ----- hdl/ocbb_merge.sv -----
// Merge stage: centre minus/plus each lane's half extent, saturated.
`timescale 1ns / 1ps
module ocbb_merge (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ocbb_pkg::POS_W-1:0] cx,
	input  logic signed [ocbb_pkg::POS_W-1:0] cy,
	input  logic signed [ocbb_pkg::POS_W-1:0] cz,
	input  logic [ocbb_pkg::HALF_W-1:0]       hx,
	input  logic [ocbb_pkg::HALF_W-1:0]       hy,
	input  logic [ocbb_pkg::HALF_W-1:0]       hz,
	output logic [ocbb_pkg::POS_W-1:0]        min_x,
	output logic [ocbb_pkg::POS_W-1:0]        max_x,
	output logic [ocbb_pkg::POS_W-1:0]        min_y,
	output logic [ocbb_pkg::POS_W-1:0]        max_y,
	output logic [ocbb_pkg::POS_W-1:0]        min_z,
	output logic [ocbb_pkg::POS_W-1:0]        max_z
);
	import ocbb_pkg::*;
	localparam int EW = HALF_W + 1;
	logic signed [EW-1:0] ex, ey, ez, gx, gy, gz;

	assign ex = EW'(cx);
	assign ey = EW'(cy);
	assign ez = EW'(cz);
	assign gx = $signed({1'b0, hx});
	assign gy = $signed({1'b0, hy});
	assign gz = $signed({1'b0, hz});

	always_ff @(posedge clk) begin
		if (en) begin
			min_x <= sat32(ex - gx);
			max_x <= sat32(ex + gx);
			min_y <= sat32(ey - gy);
			max_y <= sat32(ey + gy);
			min_z <= sat32(ez - gz);
			max_z <= sat32(ez + gz);
		end
	end
endmodule

// ----- hdl/oriented_cylinder_bounding_box.sv -----
// Top level: cylinder axis-aligned bounding box with three axis lanes.
// An input word passes through 65 register stages, from front math to the
// box bounds register, before its box is handed out.
// Throughput: one word per cycle while out_ready is high; each stage holds only when its
// successor is full and stalled, so bubbles collapse and input keeps flowing.
// The 28 root stages and 31 quotient stages of each lane set the latency.
// Reset (arst_n low) clears all stage valid bits and loads radius and
// half_height with 1.0 and margin with 0; no clearing pass.
`timescale 1ns / 1ps
module oriented_cylinder_bounding_box (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ocbb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ocbb_pkg::POS_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] axis_y,
	input  logic signed [ocbb_pkg::AXIS_W-1:0] axis_z,
	input  logic signed [ocbb_pkg::POS_W-1:0] centre_x,
	input  logic signed [ocbb_pkg::POS_W-1:0] centre_y,
	input  logic signed [ocbb_pkg::POS_W-1:0] centre_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ocbb_pkg::POS_W-1:0] min_x,
	output logic signed [ocbb_pkg::POS_W-1:0] max_x,
	output logic signed [ocbb_pkg::POS_W-1:0] min_y,
	output logic signed [ocbb_pkg::POS_W-1:0] max_y,
	output logic signed [ocbb_pkg::POS_W-1:0] min_z,
	output logic signed [ocbb_pkg::POS_W-1:0] max_z
);
	import ocbb_pkg::*;

	logic [CFG_W-1:0] radius_q, half_height_q, margin_q;
	logic [NSTG-1:0]  vld_q;
	logic [NSTG:0]    rdy;
	stage_en_t        en;
	logic [HALF_W-1:0] hx, hy, hz;
	logic [POS_W-1:0] mnx, mxx, mny, mxy, mnz, mxz;

	// Centres ride along a shift line beside the lanes.
	logic signed [POS_W-1:0] cx_s [HALF_STG+1];
	logic signed [POS_W-1:0] cy_s [HALF_STG+1];
	logic signed [POS_W-1:0] cz_s [HALF_STG+1];

	// Configuration is always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= CFG_W'(65536);
			half_height_q <= CFG_W'(65536);
			margin_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIUS: radius_q      <= cfg_data[CFG_W-1:0];
				CFG_HALF_H: half_height_q <= cfg_data[CFG_W-1:0];
				CFG_MARGIN: margin_q      <= cfg_data[CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on.
	assign rdy[NSTG] = out_ready;
	for (genvar k = 0; k < NSTG; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end
	assign en       = rdy[NSTG-1:0];
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cx_s[0] <= centre_x;
			cy_s[0] <= centre_y;
			cz_s[0] <= centre_z;
		end
		for (int k = 1; k <= HALF_STG; k++) begin
			if (en[k]) begin
				cx_s[k] <= cx_s[k-1];
				cy_s[k] <= cy_s[k-1];
				cz_s[k] <= cz_s[k-1];
			end
		end
	end

	ocbb_lane u_lane_x (
		.clk(clk), .en(en), .a_own(axis_x), .a_o1(axis_y), .a_o2(axis_z),
		.radius(radius_q), .half_height(half_height_q), .margin(margin_q), .half(hx)
	);
	ocbb_lane u_lane_y (
		.clk(clk), .en(en), .a_own(axis_y), .a_o1(axis_x), .a_o2(axis_z),
		.radius(radius_q), .half_height(half_height_q), .margin(margin_q), .half(hy)
	);
	ocbb_lane u_lane_z (
		.clk(clk), .en(en), .a_own(axis_z), .a_o1(axis_x), .a_o2(axis_y),
		.radius(radius_q), .half_height(half_height_q), .margin(margin_q), .half(hz)
	);

	ocbb_merge u_merge (
		.clk(clk), .en(en[NSTG-1]),
		.cx(cx_s[HALF_STG]), .cy(cy_s[HALF_STG]), .cz(cz_s[HALF_STG]),
		.hx(hx), .hy(hy), .hz(hz),
		.min_x(mnx), .max_x(mxx), .min_y(mny), .max_y(mxy), .min_z(mnz), .max_z(mxz)
	);

	assign out_valid = vld_q[NSTG-1];
	assign min_x = mnx;
	assign max_x = mxx;
	assign min_y = mny;
	assign max_y = mxy;
	assign min_z = mnz;
	assign max_z = mxz;
endmodule

// ----- hdl/ocbb_checker.sv -----
// Port-level checker for the cylinder bounding box block, with its bind.
`timescale 1ns / 1ps
module ocbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [31:0] min_x,
	input logic signed [31:0] max_x,
	input logic signed [31:0] min_y,
	input logic signed [31:0] max_y
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_x) && $stable(max_x))
		else $error("output word changed while stalled");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output pending");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_x <= max_x && min_y <= max_y)
		else $error("box bounds out of order");
endmodule

bind oriented_cylinder_bounding_box ocbb_checker u_ocbb_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y)
);
